FILE: sv/tbt_pkg.sv
package tbt_pkg;

    // Default sizing of the timer banks.
    localparam int TIMERS_DEF = 16;
    localparam int TIME_W_DEF = 32;

    // Field widths of the words on the two channels.
    localparam int KIND_W     = 2;
    localparam int INDEX_W    = 4;
    localparam int FIELD_T_W  = 32;
    localparam int STATUS_W   = 2;

    // A tick reports at most this many expiries.
    localparam int MAX_RESULTS = 32;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CREATE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNCREATED = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic                 direction;
        logic [INDEX_W-1:0]   timer_index;
        logic [FIELD_T_W-1:0] period;
        logic                 auto_reload;
        logic [FIELD_T_W-1:0] tick_delta;
    } in_word_t;

    typedef struct packed {
        logic                fired;
        logic                out_direction;
        logic [INDEX_W-1:0]  out_index;
        logic [STATUS_W-1:0] status;
        logic                last;
    } out_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_START_WR,
        S_SCAN,
        S_EXEC,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic tick_init;
        logic create;
        logic start_err;
        logic start_rd;
        logic start_wr;
        logic scan_rd;
        logic exec;
        logic finish;
        logic bank;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              start_ok;
        logic              out_free;
        logic              slot_live;
        logic              exec_stall;
    } stat_t;

    function automatic out_word_t make_out(input logic fired, input logic dir,
                                           input logic [INDEX_W-1:0] idx,
                                           input logic [STATUS_W-1:0] status,
                                           input logic last);
        out_word_t w;
        w.fired         = fired;
        w.out_direction = dir;
        w.out_index     = idx;
        w.status        = status;
        w.last          = last;
        return w;
    endfunction

endpackage

FILE: sv/tbt_ram.sv
module tbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/tbt_ctrl.sv
module tbt_ctrl #(
    parameter int TIMERS = tbt_pkg::TIMERS_DEF,
    localparam int SLOT_W = (TIMERS > 1) ? $clog2(TIMERS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tbt_pkg::stat_t      stat,
    output tbt_pkg::cmd_t       cmd,
    output logic [SLOT_W-1:0]   slot
);

    import tbt_pkg::*;

    state_t            state_reg, state_next;
    logic              bank_reg, bank_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic              last_slot;

    assign last_slot = (slot_reg == SLOT_W'(TIMERS - 1));
    assign slot      = slot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            bank_reg  <= 1'b0;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            slot_reg  <= slot_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        bank_next  = bank_reg;
        slot_next  = slot_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.bank   = bank_reg;

        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (stat.kind)
                    KIND_TICK: begin
                        cmd.tick_init = 1'b1;
                        bank_next     = 1'b0;
                        slot_next     = '0;
                        state_next    = S_SCAN;
                    end
                    KIND_CREATE: begin
                        if (stat.out_free) begin
                            cmd.create = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    KIND_START: begin
                        if (!stat.start_ok) begin
                            if (stat.out_free) begin
                                cmd.start_err = 1'b1;
                                state_next    = S_IDLE;
                            end
                        end else begin
                            cmd.start_rd = 1'b1;
                            state_next   = S_START_WR;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_START_WR: begin
                if (stat.out_free) begin
                    cmd.start_wr = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SCAN, S_EXEC: begin
                // Scan reads a live slot; exec, which can stall, updates it.
                if ((state_reg == S_SCAN && stat.slot_live) ||
                    (state_reg == S_EXEC && stat.exec_stall)) begin
                    cmd.scan_rd = (state_reg == S_SCAN);
                    state_next  = S_EXEC;
                end else begin
                    cmd.exec   = (state_reg == S_EXEC);
                    state_next = S_SCAN;
                    if (last_slot) begin
                        slot_next = '0;
                        if (bank_reg) begin
                            state_next = S_FINISH;
                        end else begin
                            bank_next = 1'b1;
                        end
                    end else begin
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/tbt_datapath.sv
module tbt_datapath #(
    parameter int TIMERS = tbt_pkg::TIMERS_DEF,
    parameter int TIME_W = tbt_pkg::TIME_W_DEF,
    localparam int SLOT_W = (TIMERS > 1) ? $clog2(TIMERS) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tbt_pkg::in_word_t     s_data,
    input  tbt_pkg::cmd_t         cmd,
    input  logic [SLOT_W-1:0]     slot,
    output tbt_pkg::stat_t        stat,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tbt_pkg::out_word_t    m_data
);

    import tbt_pkg::*;

    localparam int USED_W = $clog2(TIMERS + 1);
    localparam int ADDR_W = SLOT_W + 1;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam int RCNT_W = $clog2(MAX_RESULTS + 1);

    in_word_t              item_reg;
    logic [USED_W-1:0]     used_reg [2];
    logic [TIMERS-1:0]     reload_reg [2];
    logic [TIMERS-1:0]     run_reg [2];
    logic                  pend_valid_reg;
    logic                  pend_bank_reg;
    logic [INDEX_W-1:0]    pend_index_reg;
    logic [RCNT_W-1:0]     res_cnt_reg;
    logic                  m_valid_reg;
    out_word_t             m_data_reg;

    logic                  dir;
    logic [TIME_W+FIELD_T_W-1:0] period_ext, delta_ext;
    logic [TIME_W-1:0]     period_in, delta_in;
    logic [SLOT_W+INDEX_W-1:0] start_ext, new_ext, scan_ext;
    logic [SLOT_W-1:0]     start_slot, new_slot;
    logic [USED_W-1:0]     used_dir;
    logic                  full;
    logic                  out_free;

    logic [ADDR_W-1:0]     rd_addr, cnt_wr_addr, per_wr_addr;
    logic                  rd_en, cnt_wr_en, per_wr_en;
    logic [TIME_W-1:0]     cnt_wr_data, cnt_rd, per_rd;

    logic [TIME_W:0]       up_sum;
    logic [TIME_W-1:0]     up_cnt, dn_cnt, adv_cnt, exec_cnt;
    logic                  hit, reload_now, record;

    logic                  out_load;
    out_word_t             out_word;

    assign dir        = item_reg.direction;
    assign period_ext = {{TIME_W{1'b0}}, item_reg.period};
    assign delta_ext  = {{TIME_W{1'b0}}, item_reg.tick_delta};
    assign period_in  = period_ext[TIME_W-1:0];
    assign delta_in   = delta_ext[TIME_W-1:0];

    assign used_dir   = used_reg[dir];
    assign full       = (used_dir == USED_W'(TIMERS));
    assign start_ext  = {{SLOT_W{1'b0}}, item_reg.timer_index};
    assign start_slot = start_ext[SLOT_W-1:0];
    assign new_slot   = used_dir[SLOT_W-1:0];
    assign new_ext    = {{INDEX_W{1'b0}}, new_slot};
    assign scan_ext   = {{INDEX_W{1'b0}}, slot};
    assign out_free   = !m_valid_reg || m_ready;

    // Count and period stores, both banks in one memory each.
    assign rd_en       = cmd.start_rd || cmd.scan_rd;
    assign rd_addr     = cmd.start_rd ? {dir, start_slot} : {cmd.bank, slot};
    assign cnt_wr_en   = cmd.start_wr || cmd.exec;
    assign cnt_wr_addr = cmd.start_wr ? {dir, start_slot} : {cmd.bank, slot};
    assign cnt_wr_data = cmd.start_wr ? (dir ? per_rd : '0) : exec_cnt;
    assign per_wr_en   = cmd.create && !full;
    assign per_wr_addr = {dir, new_slot};

    tbt_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (cnt_rd)
    );

    tbt_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_per_ram (
        .aclk    (aclk),
        .wr_en   (per_wr_en),
        .wr_addr (per_wr_addr),
        .wr_data (period_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (per_rd)
    );

    // Advance one slot: saturating add or subtract, then expiry check.
    assign up_sum     = {1'b0, cnt_rd} + {1'b0, delta_in};
    assign up_cnt     = up_sum[TIME_W] ? '1 : up_sum[TIME_W-1:0];
    assign dn_cnt     = (cnt_rd > delta_in) ? (cnt_rd - delta_in) : '0;
    assign adv_cnt    = cmd.bank ? dn_cnt : up_cnt;
    assign hit        = cmd.bank ? (dn_cnt == '0) : (up_cnt >= per_rd);
    assign reload_now = reload_reg[cmd.bank][slot];
    assign record     = hit && (res_cnt_reg < RCNT_W'(MAX_RESULTS));

    always_comb begin
        if (!hit) begin
            exec_cnt = adv_cnt;
        end else if (reload_now) begin
            exec_cnt = cmd.bank ? per_rd : '0;
        end else begin
            exec_cnt = cmd.bank ? '0 : per_rd;
        end
    end

    always_comb begin
        stat.kind       = item_reg.kind;
        stat.start_ok   = ({{USED_W{1'b0}}, item_reg.timer_index} <
                           {{INDEX_W{1'b0}}, used_dir}) ? 1'b1 : 1'b0;
        stat.out_free   = out_free;
        stat.slot_live  = run_reg[cmd.bank][slot];
        stat.exec_stall = record && pend_valid_reg && !out_free;
    end

    // One expiry is held back so that the final one can carry last.
    always_comb begin
        out_load = 1'b0;
        out_word = '0;
        if (cmd.create) begin
            out_load = 1'b1;
            out_word = full ? make_out(1'b0, dir, '0, STATUS_FULL, 1'b1)
                            : make_out(1'b0, dir, new_ext[INDEX_W-1:0], STATUS_OK, 1'b1);
        end else if (cmd.start_err) begin
            out_load = 1'b1;
            out_word = make_out(1'b0, dir, item_reg.timer_index, STATUS_UNCREATED, 1'b1);
        end else if (cmd.start_wr) begin
            out_load = 1'b1;
            out_word = make_out(1'b0, dir, item_reg.timer_index, STATUS_OK, 1'b1);
        end else if (cmd.exec && record && pend_valid_reg) begin
            out_load = 1'b1;
            out_word = make_out(1'b1, pend_bank_reg, pend_index_reg, STATUS_OK, 1'b0);
        end else if (cmd.finish) begin
            out_load = 1'b1;
            out_word = pend_valid_reg
                     ? make_out(1'b1, pend_bank_reg, pend_index_reg, STATUS_OK, 1'b1)
                     : make_out(1'b0, 1'b0, '0, STATUS_OK, 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg[0]    <= '0;
            used_reg[1]    <= '0;
            reload_reg[0]  <= '0;
            reload_reg[1]  <= '0;
            run_reg[0]     <= '0;
            run_reg[1]     <= '0;
            pend_valid_reg <= 1'b0;
            res_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.create && !full) begin
                used_reg[dir]             <= used_dir + USED_W'(1);
                reload_reg[dir][new_slot] <= item_reg.auto_reload;
                run_reg[dir][new_slot]    <= 1'b0;
            end
            if (cmd.start_wr) begin
                run_reg[dir][start_slot] <= 1'b1;
            end
            if (cmd.exec && hit && !reload_now) begin
                run_reg[cmd.bank][slot] <= 1'b0;
            end
            if (cmd.tick_init) begin
                pend_valid_reg <= 1'b0;
                res_cnt_reg    <= '0;
            end else if (cmd.exec && record) begin
                pend_valid_reg <= 1'b1;
                res_cnt_reg    <= res_cnt_reg + RCNT_W'(1);
            end else if (cmd.finish) begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        if (cmd.exec && record) begin
            pend_bank_reg  <= cmd.bank;
            pend_index_reg <= scan_ext[INDEX_W-1:0];
        end
        if (out_load) begin
            m_data_reg <= out_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: sv/timer_bank_tick_unit.sv
// Sequence, N slots per bank: a create or failed start word is loaded into the output register
// from the dispatch state, a good start word from the start-write state after its memory read;
// the next word is taken once the unit is back in idle. A tick spends a setup step in dispatch,
// a scan step per stopped slot and scan and exec steps per running slot over all 2N slots, and
// a finish step for the final word; a word can also wait for m_ready before it is loaded.
// Reset (aresetn low, synchronous) empties both banks and stops every slot; memories keep data.
module timer_bank_tick_unit #(
    parameter int TIMERS_PER_BANK = tbt_pkg::TIMERS_DEF,
    parameter int TIME_WIDTH      = tbt_pkg::TIME_W_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tbt_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tbt_pkg::out_word_t m_data
);

    import tbt_pkg::*;

    localparam int SLOT_W = (TIMERS_PER_BANK > 1) ? $clog2(TIMERS_PER_BANK) : 1;

    // The controller sequences each item and walks the slot index during a tick;
    // the datapath holds the slot flags, the count and period memories and the
    // output register, and reports back what the controller needs to branch on.
    // Counts and periods need no clearing because a slot is always created and
    // started before its entries are read.
    cmd_t              cmd;
    stat_t             stat;
    logic [SLOT_W-1:0] slot;

    tbt_ctrl #(.TIMERS(TIMERS_PER_BANK)) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd),
        .slot    (slot)
    );

    // Every result word passes through the output register, so the datapath keeps
    // working while the previous word waits for m_ready, until it must load another.
    tbt_datapath #(.TIMERS(TIMERS_PER_BANK), .TIME_W(TIME_WIDTH)) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .slot    (slot),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
